@@ rtl/euler_rotate_point_3d_defines.svh @@
// Assertion macros shared by the RTL of the point rotation block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef EULER_ROTATE_POINT_3D_DEFINES_SVH
`define EULER_ROTATE_POINT_3D_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERP3_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ERP3_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/erp3_pkg.sv @@
package erp3_pkg;

  localparam int CoordWidthDef = 32;
  localparam int AngleWidthDef = 16;
  localparam int CfgDataWidth  = 16;
  localparam int CfgIdxWidth   = 2;
  localparam int CoefWidth     = 18;

  // Cycles from an angle write until the coefficient registers hold the new matrix.
  localparam int SettleCycles = 4;
  localparam int SettleWidth  = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2
  } cfg_reg_e;

  typedef logic signed [CoefWidth-1:0] coef_t;

  // Quarter-wave sine table, Q1.16, 64 steps per quarter turn.
  localparam logic [16:0] QSIN [65] = '{
    17'd0,     17'd1608,  17'd3216,  17'd4821,  17'd6424,  17'd8022,  17'd9616,  17'd11204,
    17'd12785, 17'd14359, 17'd15924, 17'd17479, 17'd19024, 17'd20557, 17'd22078, 17'd23586,
    17'd25080, 17'd26558, 17'd28020, 17'd29466, 17'd30893, 17'd32303, 17'd33692, 17'd35062,
    17'd36410, 17'd37736, 17'd39040, 17'd40320, 17'd41576, 17'd42806, 17'd44011, 17'd45190,
    17'd46341, 17'd47464, 17'd48559, 17'd49624, 17'd50660, 17'd51665, 17'd52639, 17'd53581,
    17'd54491, 17'd55368, 17'd56212, 17'd57022, 17'd57798, 17'd58538, 17'd59244, 17'd59914,
    17'd60547, 17'd61145, 17'd61705, 17'd62228, 17'd62714, 17'd63162, 17'd63572, 17'd63944,
    17'd64277, 17'd64571, 17'd64827, 17'd65043, 17'd65220, 17'd65358, 17'd65457, 17'd65516,
    17'd65536
  };

  // Q1.16 product with round half up. Operands stay within +/-1.0, so the
  // result fits the coefficient width.
  function automatic coef_t qmul(input coef_t a, input coef_t b);
    logic signed [2*CoefWidth-1:0] prod;
    prod = (2*CoefWidth)'(a) * (2*CoefWidth)'(b) + (2*CoefWidth)'(32768);
    return coef_t'(prod >>> 16);
  endfunction

  function automatic coef_t clamp_coef(input logic signed [CoefWidth:0] v);
    coef_t res;
    if (v[CoefWidth] != v[CoefWidth-1]) begin
      res = v[CoefWidth] ? {1'b1, {(CoefWidth-1){1'b0}}} : {1'b0, {(CoefWidth-1){1'b1}}};
    end else begin
      res = v[CoefWidth-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/euler_rotate_point_3d.sv @@
// A point passes the input, partial-product, row-sum, rounding and output registers.
// Throughput: one point per cycle when not stalled; five register stages run under
// per-stage valid bits. An angle write makes in_ready_o low while the 4-stage coefficient
// chain settles. Reset (rst_ni low, asynchronous) clears the angles to zero and all
// valid bits; in_ready_o stays low after reset while the identity matrix is built.
`include "euler_rotate_point_3d_defines.svh"

module euler_rotate_point_3d import erp3_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef,
  parameter int ANGLE_WIDTH = AngleWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxWidth-1:0]        cfg_idx_i,
  input  logic [CfgDataWidth-1:0]       cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  logic signed [COORD_WIDTH-1:0] coord_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] rot_x_o,
  output logic signed [COORD_WIDTH-1:0] rot_y_o,
  output logic signed [COORD_WIDTH-1:0] rot_z_o,
  output logic                          clipped_o
);

  localparam int CW     = COORD_WIDTH;
  localparam int LO_W   = (CW + 1) / 2;
  localparam int HI_W   = CW - LO_W;
  localparam int PL_W   = LO_W + CoefWidth + 1;
  localparam int PH_W   = HI_W + CoefWidth;
  localparam int SL_W   = PL_W + 2;
  localparam int SH_W   = PH_W + 2;
  localparam int FULL_W = CW + CoefWidth + 2;
  localparam int RND_W  = FULL_W - 16;
  localparam logic signed [CW-1:0] CoordMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CoordMin = {1'b1, {(CW-1){1'b0}}};

  // Angle registers and settle counter.
  logic [ANGLE_WIDTH-1:0] angle_x_q, angle_x_d;
  logic [ANGLE_WIDTH-1:0] angle_y_q, angle_y_d;
  logic [ANGLE_WIDTH-1:0] angle_z_q, angle_z_d;
  logic [SettleWidth-1:0] settle_q, settle_d;
  coef_t                  coef [9];

  always_comb begin
    angle_x_d = angle_x_q;
    angle_y_d = angle_y_q;
    angle_z_d = angle_z_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ANGLE_X: angle_x_d = ANGLE_WIDTH'(cfg_wdata_i);
        REG_ANGLE_Y: angle_y_d = ANGLE_WIDTH'(cfg_wdata_i);
        REG_ANGLE_Z: angle_z_d = ANGLE_WIDTH'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_we_i) begin
      settle_d = SettleWidth'(SettleCycles);
    end else if (settle_q != '0) begin
      settle_d = settle_q - SettleWidth'(1);
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_x_q <= '0;
      angle_y_q <= '0;
      angle_z_q <= '0;
      settle_q  <= SettleWidth'(SettleCycles);
    end else begin
      angle_x_q <= angle_x_d;
      angle_y_q <= angle_y_d;
      angle_z_q <= angle_z_d;
      settle_q  <= settle_d;
    end
  end

  erp3_coef #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_coef (
    .clk_i    (clk_i),
    .angle_x_i(angle_x_q),
    .angle_y_i(angle_y_q),
    .angle_z_i(angle_z_q),
    .coef_o   (coef)
  );

  // Point pipeline: input, partial products, row sums, rounding, saturation.
  logic v0_q, v1_q, v2_q, v3_q, vo_q;
  logic v0_d, v1_d, v2_d, v3_d, vo_d;
  logic rdy0, rdy1, rdy2, rdy3, rdy_o;
  logic in_acc;

  logic signed [CW-1:0]     crd_q [3];
  logic signed [PL_W-1:0]   plo_q [9];
  logic signed [PL_W-1:0]   plo_d [9];
  logic signed [PH_W-1:0]   phi_q [9];
  logic signed [PH_W-1:0]   phi_d [9];
  logic signed [SL_W-1:0]   slo_q [3];
  logic signed [SL_W-1:0]   slo_d [3];
  logic signed [SH_W-1:0]   shi_q [3];
  logic signed [SH_W-1:0]   shi_d [3];
  logic signed [FULL_W-1:0] full  [3];
  logic signed [RND_W-1:0]  rnd_q [3];
  logic signed [RND_W-1:0]  rnd_d [3];
  logic signed [CW-1:0]     rot_q [3];
  logic signed [CW-1:0]     rot_d [3];
  logic                     clip_q, clip_d;

  // A stage takes new data when it is empty or its content moves on.
  assign rdy_o      = !vo_q || out_ready_i;
  assign rdy3       = !v3_q || rdy_o;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_ready_o = rdy0 && (settle_q == '0);
  assign in_acc     = in_valid_i && in_ready_o;

  assign v0_d = rdy0  ? in_acc : v0_q;
  assign v1_d = rdy1  ? v0_q   : v1_q;
  assign v2_d = rdy2  ? v1_q   : v2_q;
  assign v3_d = rdy3  ? v2_q   : v3_q;
  assign vo_d = rdy_o ? v3_q   : vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      vo_q <= vo_d;
    end
  end

  // Each coordinate is split into an unsigned low half and a signed high half
  // so that no multiplier is wider than half a coordinate by a coefficient.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        plo_d[3*r+j] = PL_W'(coef[3*r+j]) * PL_W'($signed({1'b0, crd_q[j][LO_W-1:0]}));
        phi_d[3*r+j] = PH_W'(coef[3*r+j]) * PH_W'($signed(crd_q[j][CW-1:LO_W]));
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      slo_d[r] = SL_W'(plo_q[3*r]) + SL_W'(plo_q[3*r+1]) + SL_W'(plo_q[3*r+2]);
      shi_d[r] = SH_W'(phi_q[3*r]) + SH_W'(phi_q[3*r+1]) + SH_W'(phi_q[3*r+2]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      full[r]  = (FULL_W'(shi_q[r]) <<< LO_W) + FULL_W'(slo_q[r])
                 + (FULL_W'(1) << 15);
      rnd_d[r] = full[r][FULL_W-1:16];
    end
  end

  always_comb begin
    clip_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      if ((&rnd_q[r][RND_W-1:CW-1]) || !(|rnd_q[r][RND_W-1:CW-1])) begin
        rot_d[r] = rnd_q[r][CW-1:0];
      end else begin
        rot_d[r] = rnd_q[r][RND_W-1] ? CoordMin : CoordMax;
        clip_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      crd_q[0] <= coord_x_i;
      crd_q[1] <= coord_y_i;
      crd_q[2] <= coord_z_i;
    end
    if (rdy1 && v0_q) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
    if (rdy2 && v1_q) begin
      slo_q <= slo_d;
      shi_q <= shi_d;
    end
    if (rdy3 && v2_q) begin
      rnd_q <= rnd_d;
    end
    if (rdy_o && v3_q) begin
      rot_q  <= rot_d;
      clip_q <= clip_d;
    end
  end

  assign out_valid_o = vo_q;
  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];
  assign clipped_o   = clip_q;

  `ERP3_ASSERT_NEXT(a_cfg_blocks_input, cfg_we_i, !in_ready_o,
                    "input request accepted while the matrix is being rebuilt")
  `ERP3_ASSERT_SAME(a_clip_at_bound, vo_q && clip_q,
                    rot_q[0] == CoordMax || rot_q[0] == CoordMin ||
                    rot_q[1] == CoordMax || rot_q[1] == CoordMin ||
                    rot_q[2] == CoordMax || rot_q[2] == CoordMin,
                    "clipped flag set without a saturated coordinate")

endmodule

@@ rtl/erp3_coef.sv @@
module erp3_coef import erp3_pkg::*; #(
  parameter int ANGLE_WIDTH = AngleWidthDef
) (
  input  logic                   clk_i,
  input  logic [ANGLE_WIDTH-1:0] angle_x_i,
  input  logic [ANGLE_WIDTH-1:0] angle_y_i,
  input  logic [ANGLE_WIDTH-1:0] angle_z_i,
  output coef_t                  coef_o [9]
);

  localparam int AW = ANGLE_WIDTH;
  localparam logic [AW-1:0] QuarterTurn = AW'(1) << (AW-2);

  // Interpolated sine. The phase is doubled so that the interpolation step
  // and its rounding term stay well formed when there are no fraction bits.
  function automatic coef_t sine_f(input logic [AW-1:0] a);
    logic [1:0]    quad;
    logic [AW-2:0] ph;
    logic [AW-1:0] ph2;
    logic [6:0]    idx;
    logic [AW-8:0] frx;
    logic [16:0]   base;
    logic [16:0]   nxt;
    logic [10:0]   diff;
    logic [AW+3:0] prod;
    logic [16:0]   mag;
    quad = a[AW-1:AW-2];
    ph   = {1'b0, a[AW-3:0]};
    if (quad[0]) begin
      ph = QuarterTurn[AW-2:0] - ph;
    end
    ph2  = {ph, 1'b0};
    idx  = ph2[AW-1 -: 7];
    frx  = ph2[AW-8:0];
    base = QSIN[idx];
    nxt  = idx[6] ? QSIN[idx] : QSIN[idx + 7'd1];
    diff = 11'(nxt - base);
    prod = (AW+4)'(diff) * (AW+4)'(frx) + ((AW+4)'(1) << (AW-8));
    mag  = base + 17'(prod >> (AW-7));
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  coef_t sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
  coef_t sysx_q, cysx_q, cxsz_q, cxcz_q, nsycx_q, sxp_q, cycx_q;
  coef_t cycz_q, sycz_q, cysz_q, sysz_q, sz2_q, cz2_q;
  coef_t sysxsz_q, cysxsz_q, sysxcz_q, cysxcz_q;
  coef_t coef_q [9];

  // The chain is free running from the angle registers; the top level holds
  // off input requests until every stage reflects the current angles.
  always_ff @(posedge clk_i) begin
    sx_q <= sine_f(angle_x_i);
    cx_q <= sine_f(angle_x_i + QuarterTurn);
    sy_q <= sine_f(angle_y_i);
    cy_q <= sine_f(angle_y_i + QuarterTurn);
    sz_q <= sine_f(angle_z_i);
    cz_q <= sine_f(angle_z_i + QuarterTurn);

    sysx_q  <= qmul(sy_q, sx_q);
    cysx_q  <= qmul(cy_q, sx_q);
    cxsz_q  <= qmul(cx_q, sz_q);
    cxcz_q  <= qmul(cx_q, cz_q);
    nsycx_q <= -qmul(sy_q, cx_q);
    sxp_q   <= sx_q;
    cycx_q  <= qmul(cy_q, cx_q);
    cycz_q  <= qmul(cy_q, cz_q);
    sycz_q  <= qmul(sy_q, cz_q);
    cysz_q  <= qmul(cy_q, sz_q);
    sysz_q  <= qmul(sy_q, sz_q);
    sz2_q   <= sz_q;
    cz2_q   <= cz_q;

    sysxsz_q <= qmul(sysx_q, sz2_q);
    cysxsz_q <= qmul(cysx_q, sz2_q);
    sysxcz_q <= qmul(sysx_q, cz2_q);
    cysxcz_q <= qmul(cysx_q, cz2_q);

    coef_q[0] <= clamp_coef((CoefWidth+1)'(sysxsz_q) + (CoefWidth+1)'(cycz_q));
    coef_q[1] <= clamp_coef((CoefWidth+1)'(cxsz_q));
    coef_q[2] <= clamp_coef((CoefWidth+1)'(sycz_q) - (CoefWidth+1)'(cysxsz_q));
    coef_q[3] <= clamp_coef((CoefWidth+1)'(sysxcz_q) - (CoefWidth+1)'(cysz_q));
    coef_q[4] <= clamp_coef((CoefWidth+1)'(cxcz_q));
    coef_q[5] <= clamp_coef(-(CoefWidth+1)'(cysxcz_q) - (CoefWidth+1)'(sysz_q));
    coef_q[6] <= clamp_coef((CoefWidth+1)'(nsycx_q));
    coef_q[7] <= clamp_coef((CoefWidth+1)'(sxp_q));
    coef_q[8] <= clamp_coef((CoefWidth+1)'(cycx_q));
  end

  assign coef_o = coef_q;

endmodule

@@ verif/tb.sv @@
module tb;
  import erp3_pkg::*;

  localparam int CoordW = CoordWidthDef;
  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 50;
  localparam int RandomPhases = 26;
  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;
  localparam logic [CfgDataWidth-1:0] QuarterTurn = 16'h4000;
  localparam longint CoordMax = 64'sd2147483647;
  localparam longint CoordMin = -64'sd2147483648;
  localparam longint CoefMax = (64'sd1 <<< (CoefWidth - 1)) - 1;
  localparam longint CoefMin = -(64'sd1 <<< (CoefWidth - 1));
  localparam logic signed [CoordW-1:0] PosFull = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] NegFull = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] UnitQ = 32'sh0001_0000;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     clipped;
  } rotated_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]   cfg_idx_i = '0;
  logic [CfgDataWidth-1:0]  cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [CoordW-1:0] coord_x_i = '0;
  logic signed [CoordW-1:0] coord_y_i = '0;
  logic signed [CoordW-1:0] coord_z_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [CoordW-1:0] rot_x_o;
  logic signed [CoordW-1:0] rot_y_o;
  logic signed [CoordW-1:0] rot_z_o;
  logic                     clipped_o;

  point_t   point_queue[$];
  rotated_t rotated_queue[$];
  point_t   next_point;
  rotated_t want;
  logic [CfgDataWidth-1:0] angle_reg [3];
  longint   coef [9];
  int       err_cnt = 0;
  int       cycle_cnt = 0;
  int       burst_left;
  int       gap_left;
  logic [15:0] ready_pat;
  bit       tx_quiet = 1'b1;
  bit       rx_free = 1'b1;

  euler_rotate_point_3d DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .coord_z_i   (coord_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o),
    .rot_z_o     (rot_z_o),
    .clipped_o   (clipped_o)
  );

  always #4 clk_i = ~clk_i;

  // Sine in Q1.16 from the quarter-wave table, with linear interpolation
  // over the low eight bits of the phase.
  function automatic longint angle_sine(input logic [CfgDataWidth-1:0] a);
    logic [1:0]  quad;
    logic [14:0] ph;
    logic [6:0]  idx;
    logic [7:0]  fr;
    longint      base;
    longint      v;
    quad = a[15:14];
    ph = {1'b0, a[13:0]};
    if (quad[0]) begin
      ph = 15'd16384 - ph;
    end
    idx = ph[14:8];
    fr = ph[7:0];
    if (idx >= 7'd64) begin
      v = 65536;
    end else begin
      base = longint'(QSIN[idx]);
      v = base + (((longint'(QSIN[idx + 1]) - base) * longint'(fr) + 128) >>> 8);
    end
    return quad[1] ? -v : v;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint clamp_coef18(input longint v);
    if (v > CoefMax) return CoefMax;
    if (v < CoefMin) return CoefMin;
    return v;
  endfunction

  function automatic void rebuild_matrix();
    longint sx, cx, sy, cy, sz, cz, sysx, cysx;
    sx = angle_sine(angle_reg[REG_ANGLE_X]);
    cx = angle_sine(angle_reg[REG_ANGLE_X] + QuarterTurn);
    sy = angle_sine(angle_reg[REG_ANGLE_Y]);
    cy = angle_sine(angle_reg[REG_ANGLE_Y] + QuarterTurn);
    sz = angle_sine(angle_reg[REG_ANGLE_Z]);
    cz = angle_sine(angle_reg[REG_ANGLE_Z] + QuarterTurn);
    sysx = fx_mul(sy, sx);
    cysx = fx_mul(cy, sx);
    coef[0] = clamp_coef18(fx_mul(sysx, sz) + fx_mul(cy, cz));
    coef[1] = clamp_coef18(fx_mul(cx, sz));
    coef[2] = clamp_coef18(fx_mul(sy, cz) - fx_mul(cysx, sz));
    coef[3] = clamp_coef18(fx_mul(sysx, cz) - fx_mul(cy, sz));
    coef[4] = clamp_coef18(fx_mul(cx, cz));
    coef[5] = clamp_coef18(-fx_mul(cysx, cz) - fx_mul(sy, sz));
    coef[6] = clamp_coef18(-fx_mul(sy, cx));
    coef[7] = clamp_coef18(sx);
    coef[8] = clamp_coef18(fx_mul(cy, cx));
  endfunction

  function automatic rotated_t rotate_point(input point_t p);
    rotated_t r;
    longint   acc;
    longint   sat [3];
    r.clipped = 1'b0;
    for (int row = 0; row < 3; row++) begin
      acc = (coef[3*row] * longint'($signed(p.x)) + coef[3*row+1] * longint'($signed(p.y))
             + coef[3*row+2] * longint'($signed(p.z)) + 32768) >>> 16;
      if (acc > CoordMax) begin
        acc = CoordMax;
        r.clipped = 1'b1;
      end else if (acc < CoordMin) begin
        acc = CoordMin;
        r.clipped = 1'b1;
      end
      sat[row] = acc;
    end
    r.x = CoordW'(sat[0]);
    r.y = CoordW'(sat[1]);
    r.z = CoordW'(sat[2]);
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return PosFull;
      1: return NegFull;
      2: return CoordW'(CoordMax - longint'($urandom_range(0, 1 << 20)));
      3: return CoordW'(CoordMin + longint'($urandom_range(0, 1 << 20)));
      4, 5: return CoordW'(longint'($urandom_range(0, 1 << 23)) - (1 << 22));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CfgDataWidth-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(16384 * $urandom_range(1, 3));
      3: return 16'(16384 * $urandom_range(0, 3) + $urandom_range(0, 4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [CoordW-1:0] exp_v,
                             input logic signed [CoordW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic push_point(input logic signed [CoordW-1:0] x, input logic signed [CoordW-1:0] y,
                            input logic signed [CoordW-1:0] z);
    point_queue.push_back('{x, y, z});
  endtask

  // The block is idle once every request went out, every result came back
  // and the coefficient chain has settled.
  task automatic wait_idle();
    while (point_queue.size() != 0 || in_valid_i || rotated_queue.size() != 0 || !in_ready_o)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx != RegUnused) begin
      angle_reg[idx] = val;
      rebuild_matrix();
    end
  endtask

  // Request driver: bursts of random length, separated by random gaps unless tx_quiet is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      coord_x_i <= '0;
      coord_y_i <= '0;
      coord_z_i <= '0;
      burst_left = 1;
      gap_left = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        rotated_queue.push_back(rotate_point('{coord_x_i, coord_y_i, coord_z_i}));
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (point_queue.size() != 0) begin
        next_point = point_queue.pop_front();
        coord_x_i <= next_point.x;
        coord_y_i <= next_point.y;
        coord_z_i <= next_point.z;
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = tx_quiet ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor; the ready pattern always keeps at least one set bit, so a stall ends
  // once that bit rotates into place unless the pattern is redrawn in the middle of it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_pat = 16'hFFFF;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (rotated_queue.size() == 0) begin
          $display("%0t: result with no request pending: expected none, actual %0d %0d %0d %0b",
                   $time, rot_x_o, rot_y_o, rot_z_o, clipped_o);
          err_cnt++;
        end else begin
          want = rotated_queue.pop_front();
          check_field("rot_x", want.x, rot_x_o);
          check_field("rot_y", want.y, rot_y_o);
          check_field("rot_z", want.z, rot_z_o);
          check_field("clipped", CoordW'(want.clipped), CoordW'(clipped_o));
        end
      end
      if ($urandom_range(0, 47) == 0) begin
        ready_pat = 16'($urandom) | 16'h0001;
      end
      ready_pat = {ready_pat[0], ready_pat[15:1]};
      out_ready_i <= rx_free || ready_pat[0];
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    angle_reg = '{default: '0};
    rebuild_matrix();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Identity matrix out of reset: every point passes unchanged.
    push_point('0, '0, '0);
    push_point(PosFull, NegFull, UnitQ);
    push_point(NegFull, PosFull, -UnitQ);
    push_point(-1, 1, 32'sh0000_8000);
    push_point(PosFull, PosFull, NegFull);
    wait_idle();

    // Mixed quarter turns with 45 degrees about z push the sums past the range.
    write_reg(REG_ANGLE_X, QuarterTurn);
    write_reg(REG_ANGLE_Y, 16'h8000);
    write_reg(REG_ANGLE_Z, 16'h2000);
    push_point(PosFull, PosFull, PosFull);
    push_point(NegFull, NegFull, NegFull);
    push_point(PosFull, NegFull, '0);
    push_point(UnitQ, '0, '0);
    wait_idle();

    // A write to the unused index must leave the matrix alone.
    write_reg(RegUnused, 16'hFFFF);
    write_reg(REG_ANGLE_X, 16'hFFFF);
    write_reg(REG_ANGLE_Y, 16'hC000);
    write_reg(REG_ANGLE_Z, 16'hFFFF);
    push_point(PosFull, PosFull, '0);
    push_point(NegFull, PosFull, NegFull);
    push_point(32'sh3039_0000, -32'sh0001_8000, 32'sh0000_0001);
    wait_idle();

    write_reg(REG_ANGLE_X, 16'h2000);
    write_reg(REG_ANGLE_Y, 16'h2000);
    write_reg(REG_ANGLE_Z, 16'h2000);
    tx_quiet <= 1'b0;
    rx_free <= 1'b0;
    repeat (6) push_point(rand_coord(), rand_coord(), rand_coord());

    for (int ph = 0; ph < RandomPhases; ph++) begin
      wait_idle();
      for (int r = 0; r < 3; r++) begin
        if ($urandom_range(0, 1) == 1) begin
          write_reg(CfgIdxWidth'(r), pick_angle());
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(RegUnused, 16'($urandom));
      end
      tx_quiet <= ($urandom_range(0, 3) == 0);
      rx_free <= ($urandom_range(0, 3) == 0);
      repeat (PhaseItems) push_point(rand_coord(), rand_coord(), rand_coord());
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ euler_rotate_point_3d.f @@
+incdir+rtl
rtl/erp3_pkg.sv
rtl/erp3_coef.sv
rtl/euler_rotate_point_3d.sv
verif/tb.sv
